@@ hdl/bsf_pkg.sv @@
// Shared types, constants and check functions for the slot free-list allocator.
package bsf_pkg;

  localparam int HEAP_BYTES  = 65536;
  localparam int SLOT_STRIDE = 8;
  localparam int NUM_BUCKETS = 8;
  localparam int SLOT_COUNT  = (HEAP_BYTES + SLOT_STRIDE - 1) / SLOT_STRIDE;
  localparam int IDX_W       = $clog2(SLOT_COUNT);
  localparam int STRIDE_W    = $clog2(SLOT_STRIDE);
  localparam int TOK_W       = 17;
  localparam int VER_W       = 32;
  localparam int OFF_W       = 16;
  localparam int BYTES_W     = 11;
  localparam int BKT_W       = 3;
  localparam int SLOT_ST_W   = 5;
  localparam int LIMIT_W     = 17;
  localparam int ADDR_W      = 3;

  localparam logic [TOK_W-1:0] CAP_MAX = TOK_W'(HEAP_BYTES);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);
  localparam logic [0:0] REG_HEAP_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ACT_POP   = 2'd0,
    ACT_PUSH  = 2'd1,
    ACT_CARVE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_DONE          = 4'd0,
    ST_EMPTY         = 4'd1,
    ST_BAD_HEAD      = 4'd2,
    ST_HEAD_MISALIGN = 4'd3,
    ST_CLAIM_FAIL    = 4'd4,
    ST_OUT_OF_BOUNDS = 4'd5,
    ST_MISALIGNED    = 4'd6,
    ST_RELEASE_FAIL  = 4'd7,
    ST_CARVE_REFUSED = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } fsm_t;

  typedef struct packed {
    logic [VER_W-1:0] ver;
    logic [TOK_W-1:0] tok;
  } head_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic can_commit;
  } sts_t;

  // Token lies wholly inside the capacity.
  function automatic logic tok_ok(input logic [TOK_W-1:0] tok,
                                  input logic [TOK_W-1:0] cap,
                                  input logic [BYTES_W-1:0] bytes);
    logic [TOK_W:0] span;
    span = {1'b0, tok} - (TOK_W+1)'(1) + (TOK_W+1)'(bytes);
    return (tok != '0) && (tok <= cap) && (span <= {1'b0, cap});
  endfunction

  // Offset out of bounds for push and carve.
  function automatic logic off_oob(input logic [OFF_W-1:0] off,
                                   input logic [TOK_W-1:0] cap,
                                   input logic [BYTES_W-1:0] bytes);
    logic [TOK_W:0] span;
    span = (TOK_W+1)'(off) + (TOK_W+1)'(bytes);
    return ((TOK_W)'(off) >= cap) || (span > {1'b0, cap});
  endfunction

endpackage

@@ hdl/bsf_ctrl.sv @@
// Sequencer for the allocator: clearing pass, accept, lookup, update.
module bsf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bsf_pkg::sts_t sts,
  output bsf_pkg::cmd_t cmd
);
  import bsf_pkg::*;

  fsm_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance and issue commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (sts.can_commit) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

@@ hdl/bsf_dpath.sv @@
// Datapath: list heads, link and state memories, checks and result word.
module bsf_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bsf_pkg::cmd_t                 cmd,
  output bsf_pkg::sts_t                 sts,
  input  logic [1:0]                    in_action,
  input  logic [bsf_pkg::BKT_W-1:0]     in_bucket,
  input  logic [bsf_pkg::OFF_W-1:0]     in_slot_offset,
  input  logic [bsf_pkg::BYTES_W-1:0]   in_slot_bytes,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_status,
  output logic [bsf_pkg::OFF_W-1:0]     out_granted_offset,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsf_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata
);
  import bsf_pkg::*;

  logic [LIMIT_W-1:0]   heap_limit_r;
  head_t                heads_r [NUM_BUCKETS];
  logic [TOK_W-1:0]     link_mem [SLOT_COUNT];
  logic [SLOT_ST_W-1:0] slot_mem [SLOT_COUNT];
  logic [TOK_W-1:0]     link_q_r;
  logic [SLOT_ST_W-1:0] slot_q_r;
  logic [IDX_W-1:0]     clr_cnt_r;
  logic [1:0]           act_r;
  logic [BKT_W-1:0]     bkt_r;
  logic [OFF_W-1:0]     off_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, status_nxt;
  logic [OFF_W-1:0]     out_granted_r, granted_nxt;

  logic [TOK_W-1:0]     cap;
  head_t                head_cur, head_new;
  logic [TOK_W-1:0]     tok_m1;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic                 head_we, link_we, slot_we;
  logic [TOK_W-1:0]     link_wd, nxt_tok;
  logic [SLOT_ST_W-1:0] slot_wd, free_code, live_code;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_HEAP_LIMIT) begin
      heap_limit_r <= pwdata[LIMIT_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? 32'(heap_limit_r) : '0;

  assign cap = (heap_limit_r > CAP_MAX) ? CAP_MAX : heap_limit_r;

  // Latch the input word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r   <= in_action;
      bkt_r   <= in_bucket;
      off_r   <= in_slot_offset;
      bytes_r <= in_slot_bytes;
    end
  end

  assign head_cur  = heads_r[bkt_r];
  assign tok_m1    = head_cur.tok - TOK_W'(1);
  assign free_code = {1'b0, bkt_r, 1'b1};
  assign live_code = {1'b0, bkt_r, 1'b0} + SLOT_ST_W'(2);
  assign rd_addr   = (act_r == ACT_POP) ? tok_m1[STRIDE_W +: IDX_W]
                                        : off_r[STRIDE_W +: IDX_W];

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
    end
  end
  assign sts.clear_last = (clr_cnt_r == IDX_W'(SLOT_COUNT - 1));
  assign sts.can_commit = !out_valid_r || !out_stall;

  // Evaluate the action on the read data
  always_comb begin
    status_nxt  = ST_DONE;
    granted_nxt = '0;
    head_we     = 1'b0;
    head_new    = head_cur;
    link_we     = 1'b0;
    link_wd     = head_cur.tok;
    slot_we     = 1'b0;
    slot_wd     = live_code;
    nxt_tok     = link_q_r;
    case (act_r)
      ACT_POP: begin
        if (head_cur.tok == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!tok_ok(head_cur.tok, cap, bytes_r)) begin
          status_nxt = ST_BAD_HEAD;
        end else if (tok_m1[STRIDE_W-1:0] != '0) begin
          status_nxt = ST_HEAD_MISALIGN;
        end else begin
          if (link_q_r != '0 && !tok_ok(link_q_r, cap, bytes_r)) nxt_tok = '0;
          head_we      = 1'b1;
          head_new.tok = nxt_tok;
          head_new.ver = head_cur.ver + VER_W'(1);
          if (slot_q_r == free_code) begin
            slot_we     = 1'b1;
            granted_nxt = tok_m1[OFF_W-1:0];
          end else begin
            status_nxt = ST_CLAIM_FAIL;
          end
        end
      end
      ACT_PUSH, ACT_CARVE: begin
        if (off_oob(off_r, cap, bytes_r)) begin
          status_nxt = ST_OUT_OF_BOUNDS;
        end else if (off_r[STRIDE_W-1:0] != '0) begin
          status_nxt = ST_MISALIGNED;
        end else if (act_r == ACT_PUSH) begin
          if (slot_q_r != live_code) begin
            status_nxt = ST_RELEASE_FAIL;
          end else begin
            slot_we      = 1'b1;
            slot_wd      = free_code;
            link_we      = 1'b1;
            head_we      = 1'b1;
            head_new.tok = TOK_W'(off_r) + TOK_W'(1);
            head_new.ver = head_cur.ver + VER_W'(1);
          end
        end else begin
          if (slot_q_r != '0) begin
            status_nxt = ST_CARVE_REFUSED;
          end else begin
            slot_we = 1'b1;
          end
        end
      end
      default: status_nxt = ST_CARVE_REFUSED;
    endcase
  end

  // List heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUCKETS; i++) heads_r[i] <= '0;
    end else if (cmd.commit && head_we) begin
      heads_r[bkt_r] <= head_new;
    end
  end

  // Link and state memories: one write port, one registered read port
  assign wr_addr = cmd.clear ? clr_cnt_r : rd_addr;
  always_ff @(posedge clk) begin
    if (cmd.clear || (cmd.commit && link_we)) begin
      link_mem[wr_addr] <= cmd.clear ? '0 : link_wd;
    end
    link_q_r <= link_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (cmd.clear || (cmd.commit && slot_we)) begin
      slot_mem[wr_addr] <= cmd.clear ? '0 : slot_wd;
    end
    slot_q_r <= slot_mem[rd_addr];
  end

  // Result word register
  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r  <= status_nxt;
      out_granted_r <= granted_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_granted_r;

`ifndef SYNTHESIS
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("commit over an unread result word");
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed word not presented");
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_DONE) |-> (out_granted_r == '0))
    else $error("granted offset set on a failed word");
  a_no_clear_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (!cmd.commit && !cmd.accept))
    else $error("word handled during clearing pass");
`endif

endmodule

@@ hdl/bucketed_slot_freelist_core.sv @@
// Top level of the bucketed slot free-list allocator.
// Ordering: out_valid rises after the lookup state (head and memory read) and then
// the update state (check and write back), later while the result stalls.
// Issue: no new word is taken until the last one commits, due to the registered read
// of the link and slot-state memories before their write back.
// Reset: synchronous active-low; afterwards a clearing pass zeroes all 8192 entries
// of both memories while in_stall stays high. Heads and heap_limit reset at once.
module bucketed_slot_freelist_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [bsf_pkg::BKT_W-1:0]     in_bucket,
  input  logic [bsf_pkg::OFF_W-1:0]     in_slot_offset,
  input  logic [bsf_pkg::BYTES_W-1:0]   in_slot_bytes,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_status,
  output logic [bsf_pkg::OFF_W-1:0]     out_granted_offset,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsf_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  bsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsf_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_bucket          (in_bucket),
    .in_slot_offset     (in_slot_offset),
    .in_slot_bytes      (in_slot_bytes),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_offset (out_granted_offset),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata)
  );

endmodule

@@ verif/bucketed_slot_freelist_core_tb.sv @@
// Testbench for the bucketed slot free-list allocator: random and directed words checked
// against a behavioral model of the free lists.
`timescale 1ns / 1ps

module bucketed_slot_freelist_core_tb;
  import bsf_pkg::*;

  localparam int NUM_BKT = NUM_BUCKETS;
  localparam int CYCLE_LIMIT = 600000;

  // Behavioral model of heads, links and slot states, plus expected result words
  class alloc_scoreboard;
    logic [16:0] limit;
    logic [31:0] head_tok [NUM_BKT];
    logic [31:0] head_ver [NUM_BKT];
    logic [31:0] links [SLOT_COUNT];
    logic [4:0]  states [SLOT_COUNT];
    logic [3:0]  exp_status [$];
    logic [15:0] exp_grant [$];
    int errors;

    function void clear();
      limit = 17'd65536;
      errors = 0;
      foreach (head_tok[i]) begin
        head_tok[i] = '0;
        head_ver[i] = '0;
      end
      foreach (links[i]) begin
        links[i] = '0;
        states[i] = '0;
      end
    endfunction

    function logic [31:0] cap();
      return (limit < 17'd65536) ? {15'd0, limit} : 32'd65536;
    endfunction

    function bit fits(logic [31:0] tok, logic [10:0] nb);
      longint unsigned c;
      c = cap();
      if (tok == 0 || tok > c) return 0;
      return (longint'(tok) - 1 + nb) <= c;
    endfunction

    function logic [3:0] slot_chk(logic [15:0] off, logic [10:0] nb);
      longint unsigned c;
      c = cap();
      if (off >= c || longint'(off) + nb > c) return ST_OUT_OF_BOUNDS;
      if (off % SLOT_STRIDE != 0) return ST_MISALIGNED;
      return ST_DONE;
    endfunction

    // Note an accepted input word and queue its result
    function void note_input(logic [1:0] act, logic [2:0] b, logic [15:0] off,
                             logic [10:0] nb);
      logic [3:0] st;
      logic [15:0] gr;
      logic [31:0] tok, nxt, p;
      int idx;
      st = ST_DONE;
      gr = '0;
      idx = off / SLOT_STRIDE;
      case (act)
        ACT_POP: begin
          tok = head_tok[b];
          if (tok == 0) st = ST_EMPTY;
          else if (!fits(tok, nb)) st = ST_BAD_HEAD;
          else if ((tok - 1) % SLOT_STRIDE != 0) st = ST_HEAD_MISALIGN;
          else begin
            p = tok - 1;
            idx = p / SLOT_STRIDE;
            nxt = links[idx];
            if (nxt != 0 && !fits(nxt, nb)) nxt = 0;
            head_tok[b] = nxt;
            head_ver[b] = head_ver[b] + 1;
            if (states[idx] == 2 * b + 1) begin
              states[idx] = 2 * b + 2;
              gr = p[15:0];
            end else st = ST_CLAIM_FAIL;
          end
        end
        ACT_PUSH: begin
          st = slot_chk(off, nb);
          if (st == ST_DONE) begin
            if (states[idx] != 2 * b + 2) st = ST_RELEASE_FAIL;
            else begin
              states[idx] = 2 * b + 1;
              links[idx] = head_tok[b];
              head_tok[b] = off + 1;
              head_ver[b] = head_ver[b] + 1;
            end
          end
        end
        ACT_CARVE: begin
          st = slot_chk(off, nb);
          if (st == ST_DONE) begin
            if (states[idx] != 0) st = ST_CARVE_REFUSED;
            else states[idx] = 2 * b + 2;
          end
        end
        default: st = ST_CARVE_REFUSED;
      endcase
      exp_status.push_back(st);
      exp_grant.push_back(gr);
    endfunction

    // Compare a result word with the oldest expectation
    function void check_result(logic [3:0] st, logic [15:0] gr);
      logic [3:0] es;
      logic [15:0] eg;
      if (exp_status.size() == 0) begin
        $display("%0t: unexpected result word status=%0d granted=%0h", $time, st, gr);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      eg = exp_grant.pop_front();
      if (st !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, st);
        errors++;
      end
      if (gr !== eg) begin
        $display("%0t: granted_offset expected %0h actual %0h", $time, eg, gr);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [2:0] in_bucket = '0;
  logic [15:0] in_slot_offset = '0;
  logic [10:0] in_slot_bytes = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [3:0] out_status;
  logic [15:0] out_granted_offset;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  alloc_scoreboard sb;
  int cycles = 0;
  bit quiet = 0;
  bit rx_idle_en = 1;
  logic [15:0] carved [NUM_BKT][$];

  bucketed_slot_freelist_core uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_bucket, .in_slot_offset,
    .in_slot_bytes, .out_valid, .out_stall, .out_status, .out_granted_offset,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check result words and stall the result side in random bursts
  initial begin : rx_side
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_status, out_granted_offset);
      if (burst > 0) begin
        burst--;
        if (burst == 0) out_stall <= 0;
      end else if (rx_idle_en && !quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1;
      end
    end
  end

  // Send one input word, with an occasional random gap first; valid stays up after accept
  task automatic send_word(logic [1:0] act, logic [2:0] b, logic [15:0] off,
                           logic [10:0] nb);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_bucket <= b;
    in_slot_offset <= off;
    in_slot_bytes <= nb;
    do @(posedge clk); while (in_stall);
    sb.note_input(act, b, off, nb);
  endtask

  // Drop valid, wait for all expected results, then let the pipeline drain
  task automatic drain();
    in_valid <= 0;
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(logic [16:0] v);
    psel <= 1;
    pwrite <= 1;
    paddr <= ADDR_W'(REG_HEAP_LIMIT) << 2;
    pwdata <= {15'd0, v};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.limit = v;
  endtask

  // Mostly well-formed traffic over live slots in all eight buckets
  task automatic random_word();
    logic [2:0] b;
    logic [15:0] off;
    logic [10:0] nb;
    int r, k;
    b = $urandom_range(0, 7);
    nb = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 64));
    r = $urandom_range(0, 99);
    if (r < 25) begin
      off = 16'($urandom_range(0, 2047) * SLOT_STRIDE);
      send_word(ACT_CARVE, b, off, nb);
      if (sb.exp_status[$] == ST_DONE) carved[b].push_back(off);
    end else if (r < 55) begin
      if (carved[b].size() != 0 && $urandom_range(0, 5) != 0) begin
        k = $urandom_range(0, carved[b].size() - 1);
        off = carved[b][k];
        carved[b].delete(k);
      end else off = 16'($urandom);
      send_word(ACT_PUSH, b, off, nb);
    end else if (r < 90) begin
      send_word(ACT_POP, b, '0, nb);
      if (sb.exp_status[$] == ST_DONE) carved[b].push_back(sb.exp_grant[$]);
    end else begin
      send_word(2'($urandom_range(0, 3)), b, 16'($urandom), 11'($urandom));
    end
  endtask

  initial begin : stim
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty pop, carve, push, pop back, error cases at the extremes
    send_word(ACT_POP, 3'd0, '0, 11'd8);
    send_word(ACT_CARVE, 3'd0, 16'd0, 11'd8);
    send_word(ACT_CARVE, 3'd0, 16'd0, 11'd8);
    send_word(ACT_CARVE, 3'd7, 16'd65528, 11'd8);
    send_word(ACT_CARVE, 3'd7, 16'd65535, 11'd0);
    send_word(ACT_CARVE, 3'd1, 16'd65535, 11'd2047);
    send_word(ACT_CARVE, 3'd1, 16'd13, 11'd8);
    send_word(ACT_PUSH, 3'd1, 16'd0, 11'd8);
    send_word(ACT_PUSH, 3'd0, 16'd0, 11'd8);
    send_word(ACT_PUSH, 3'd7, 16'd65528, 11'd8);
    send_word(ACT_PUSH, 3'd7, 16'd65528, 11'd8);
    send_word(ACT_POP, 3'd7, '0, 11'd16);
    send_word(ACT_POP, 3'd7, '0, 11'd8);
    send_word(ACT_POP, 3'd0, '0, 11'd0);
    send_word(ACT_NONE, 3'd2, 16'hffff, 11'h7ff);
    send_word(ACT_PUSH, 3'd0, 16'd4, 11'd8);
    send_word(ACT_CARVE, 3'd2, 16'd1024, 11'd1024);
    send_word(ACT_PUSH, 3'd2, 16'd1024, 11'd1024);
    drain();

    // Shrink the slab so the pushed head goes out of range
    write_limit(17'd1500);
    send_word(ACT_POP, 3'd2, '0, 11'd1024);
    send_word(ACT_POP, 3'd2, '0, 11'd8);
    send_word(ACT_POP, 3'd2, '0, 11'd8);
    drain();
    write_limit(17'd0);
    send_word(ACT_CARVE, 3'd3, 16'd0, 11'd0);
    drain();

    // Random phases over several limits
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_limit(17'd16384);
        1: write_limit(17'd131071);
        2: write_limit(17'd4096);
        3: write_limit(17'($urandom_range(0, 20000)));
        default: write_limit(17'd65536);
      endcase
      if (ph == 5) quiet = 1;
      repeat (230) random_word();
      drain();
    end

    if (sb.errors == 0 && sb.exp_status.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
